// File: rtl/frtsc_pkg.sv
// ----------------------------------------------------------------------------
// frtsc_pkg
// Shared types and constants of the free page range table.
// ----------------------------------------------------------------------------
package frtsc_pkg;

    localparam int unsigned MAX_REGIONS_DEF     = 16;
    localparam int unsigned PAGE_INDEX_BITS_DEF = 27;

    localparam int unsigned START_W  = 27;
    localparam int unsigned COUNT_W  = 28;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned FCOUNT_W = 5;

    typedef enum logic [1:0] {
        REQ_CLAIM   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_INIT    = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    // Per-cycle command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CC_HOLD,
        CC_SHR,     // take the left neighbor's entry when at or past pos
        CC_SHL,     // take the right neighbor's entry when at or past pos
        CC_WRITE,   // write entry pos
        CC_WRITE2   // write entry pos and pos+1
    } cell_op_t;

    typedef struct packed {
        cell_op_t   op;
        logic [8:0] pos;
    } cell_ctl_t;

endpackage

// File: rtl/frtsc_cell.sv
// ----------------------------------------------------------------------------
// frtsc_cell
// One entry of the range table: holds a start and a length, and moves
// them to or from its neighbors on a shift command.
// ----------------------------------------------------------------------------
module frtsc_cell
    import frtsc_pkg::*;
#(
    parameter int unsigned SW    = 27,
    parameter int unsigned LW    = 28,
    parameter int unsigned MYIDX = 0
)
(
    input  logic            clk,
    input  cell_ctl_t       ctl,
    input  logic [SW-1:0]   left_start,
    input  logic [LW-1:0]   left_len,
    input  logic [SW-1:0]   right_start,
    input  logic [LW-1:0]   right_len,
    input  logic [SW-1:0]   wr_start,
    input  logic [LW-1:0]   wr_len,
    input  logic [SW-1:0]   wr2_start,
    input  logic [LW-1:0]   wr2_len,
    output logic [SW-1:0]   start_q,
    output logic [LW-1:0]   len_q
);

    logic [SW-1:0] start_reg, start_next;
    logic [LW-1:0] len_reg, len_next;
    logic [8:0]    me;

    assign me = 9'(MYIDX);

    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        case (ctl.op)
            CC_SHR:
            begin
                if (me >= ctl.pos)
                begin
                    start_next = left_start;
                    len_next   = left_len;
                end
            end
            CC_SHL:
            begin
                if (me >= ctl.pos)
                begin
                    start_next = right_start;
                    len_next   = right_len;
                end
            end
            CC_WRITE:
            begin
                if (me == ctl.pos)
                begin
                    start_next = wr_start;
                    len_next   = wr_len;
                end
            end
            CC_WRITE2:
            begin
                if (me == ctl.pos)
                begin
                    start_next = wr_start;
                    len_next   = wr_len;
                end
                else if (me == ctl.pos + 9'd1)
                begin
                    start_next = wr2_start;
                    len_next   = wr2_len;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        len_reg   <= len_next;
    end

    assign start_q = start_reg;
    assign len_q   = len_reg;

endmodule

// File: rtl/free_range_table_split_coalesce.sv
// ----------------------------------------------------------------------------
// free_range_table_split_coalesce
// Address-sorted free page range table with split on claim and coalescing
// on release.
// ----------------------------------------------------------------------------
// The table is a row of MAX_REGIONS cells, each holding one free range.
// A request is taken one at a time: the controller walks the valid entries
// one per cycle through a selected-entry read (a scan over range_count
// entries), then issues one or two commands that every cell applies at once
// (a shift toward higher or lower index, a write of one or two entries, or a
// shift and then a write). The result beat is held in an output register,
// so the next request can be accepted while a finished result still waits;
// a request that finishes while that register is still stalled holds in
// its done state. Overlap on release is not checked.
// ----------------------------------------------------------------------------
module free_range_table_split_coalesce
    import frtsc_pkg::*;
#(
    parameter int unsigned MAX_REGIONS     = MAX_REGIONS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic [START_W-1:0]  start_page,
    input  logic [COUNT_W-1:0]  page_count,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [FCOUNT_W-1:0] free_range_count,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [COUNT_W-1:0]  cfg_data
);

    localparam int unsigned IDX_W = $clog2(MAX_REGIONS);
    localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
    // Wide enough for start + count, one bit of headroom.
    localparam int unsigned AW    = COUNT_W + 1;
    localparam logic [AW-1:0] SPACE_END = AW'(1) << START_W;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_SCAN, S_APPLY, S_FIX, S_DONE
    } state_t;

    state_t              state_reg;
    logic                busy_reg;
    req_t                kind_reg;
    logic [AW-1:0]       s_reg, n_reg, e_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [START_W-1:0]  base_reg;
    logic [COUNT_W-1:0]  pcount_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] ostatus_reg;
    logic [FCOUNT_W-1:0] fcount_reg;
    logic                ovalid_reg;
    logic                pred_reg;
    logic [AW-1:0]       pend_reg;
    logic [COUNT_W-1:0]  plen_reg;
    cell_ctl_t           ctl;
    logic [START_W-1:0]  wr_start, wr2_start;
    logic [COUNT_W-1:0]  wr_len, wr2_len;

    logic [START_W-1:0] cs [MAX_REGIONS];
    logic [COUNT_W-1:0] cl [MAX_REGIONS];

    // Chain of cells; end cells see their own values at the open edges.
    for (genvar g = 0; g < MAX_REGIONS; g++)
    begin : g_cell
        frtsc_cell #(
            .SW    (START_W),
            .LW    (COUNT_W),
            .MYIDX (g)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .left_start  (cs[(g == 0) ? 0 : g - 1]),
            .left_len    (cl[(g == 0) ? 0 : g - 1]),
            .right_start (cs[(g == MAX_REGIONS - 1) ? g : g + 1]),
            .right_len   (cl[(g == MAX_REGIONS - 1) ? g : g + 1]),
            .wr_start    (wr_start),
            .wr_len      (wr_len),
            .wr2_start   (wr2_start),
            .wr2_len     (wr2_len),
            .start_q     (cs[g]),
            .len_q       (cl[g])
        );
    end

    // Entry under the scan pointer.
    logic [IDX_W-1:0] sel;
    logic [AW-1:0]    rb, rl, re;
    assign sel = idx_reg[IDX_W-1:0];
    assign rb  = AW'(cs[sel]);
    assign rl  = AW'(cl[sel]);
    assign re  = rb + rl;

    logic scan_end;
    assign scan_end = (idx_reg >= count_reg);

    // Init clip of the pool length.
    logic [AW-1:0] init_len;
    always_comb
    begin
        init_len = SPACE_END - AW'(base_reg);
        if (AW'(base_reg) >= SPACE_END)
            init_len = '0;
        else if (AW'(pcount_reg) < init_len)
            init_len = AW'(pcount_reg);
    end

    assign in_stall  = busy_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = ovalid_reg;
    assign status    = ostatus_reg;
    assign free_range_count = fcount_reg;

    // Control: scan for the entry, then issue one or two chain commands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            busy_reg    <= 1'b0;
            count_reg   <= '0;
            ovalid_reg  <= 1'b0;
            ostatus_reg <= '0;
            fcount_reg  <= '0;
            base_reg    <= '0;
            pcount_reg  <= '0;
            ctl         <= '{op: CC_HOLD, pos: '0};
        end
        else
        begin
            ctl <= '{op: CC_HOLD, pos: '0};
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BASE)
                    base_reg <= cfg_data[START_W-1:0];
                else
                    pcount_reg <= cfg_data;
            end
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        kind_reg  <= req_t'(req_type);
                        s_reg     <= AW'(start_page);
                        n_reg     <= AW'(page_count);
                        e_reg     <= AW'(start_page) + AW'(page_count);
                        idx_reg   <= '0;
                        pred_reg  <= 1'b0;
                        busy_reg  <= 1'b1;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (kind_reg == REQ_INIT)
                    begin
                        if (init_len == '0)
                        begin
                            count_reg  <= '0;
                            status_reg <= ST_ZERO;
                        end
                        else
                        begin
                            count_reg  <= CNT_W'(1);
                            status_reg <= ST_OK;
                            wr_start   <= base_reg;
                            wr_len     <= init_len[COUNT_W-1:0];
                            ctl        <= '{op: CC_WRITE, pos: '0};
                        end
                        state_reg <= S_DONE;
                    end
                    else if (kind_reg == REQ_NONE)
                    begin
                        status_reg <= ST_OK;
                        state_reg  <= S_DONE;
                    end
                    else if (n_reg == '0)
                    begin
                        status_reg <= ST_ZERO;
                        state_reg  <= S_DONE;
                    end
                    else if (e_reg > SPACE_END)
                    begin
                        status_reg <= ST_OVERFLOW;
                        state_reg  <= S_DONE;
                    end
                    else
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (kind_reg == REQ_CLAIM)
                    begin
                        if (scan_end)
                        begin
                            status_reg <= ST_NOTFOUND;
                            state_reg  <= S_DONE;
                        end
                        else if (s_reg >= rb && e_reg <= re)
                        begin
                            status_reg <= ST_OK;
                            state_reg  <= S_DONE;
                            if (s_reg == rb && e_reg == re)
                            begin
                                ctl       <= '{op: CC_SHL, pos: 9'(idx_reg)};
                                count_reg <= count_reg - 1'b1;
                            end
                            else if (s_reg == rb)
                            begin
                                wr_start <= e_reg[START_W-1:0];
                                wr_len   <= COUNT_W'(rl - n_reg);
                                ctl      <= '{op: CC_WRITE, pos: 9'(idx_reg)};
                            end
                            else if (e_reg == re)
                            begin
                                wr_start <= rb[START_W-1:0];
                                wr_len   <= COUNT_W'(rl - n_reg);
                                ctl      <= '{op: CC_WRITE, pos: 9'(idx_reg)};
                            end
                            else if (count_reg >= CNT_W'(MAX_REGIONS))
                                status_reg <= ST_FULL;
                            else
                            begin
                                // Open a slot after the entry, then fill both halves.
                                ctl       <= '{op: CC_SHR, pos: 9'(idx_reg) + 9'd1};
                                wr_start  <= rb[START_W-1:0];
                                wr_len    <= COUNT_W'(s_reg - rb);
                                wr2_start <= e_reg[START_W-1:0];
                                wr2_len   <= COUNT_W'(re - e_reg);
                                count_reg <= count_reg + 1'b1;
                                state_reg <= S_FIX;
                            end
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        if (!scan_end && rb < s_reg)
                        begin
                            pred_reg <= (re == s_reg);
                            pend_reg <= rb;
                            plen_reg <= rl[COUNT_W-1:0];
                            idx_reg  <= idx_reg + 1'b1;
                        end
                        else
                            state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    // Release: idx_reg is the insert position.
                    status_reg <= ST_OK;
                    state_reg  <= S_DONE;
                    if (!scan_end && e_reg == rb && pred_reg)
                    begin
                        wr_start  <= pend_reg[START_W-1:0];
                        wr_len    <= COUNT_W'(AW'(plen_reg) + n_reg + rl);
                        ctl       <= '{op: CC_SHL, pos: 9'(idx_reg)};
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_FIX;
                        idx_reg   <= idx_reg - 1'b1;
                    end
                    else if (!scan_end && e_reg == rb)
                    begin
                        wr_start <= s_reg[START_W-1:0];
                        wr_len   <= COUNT_W'(n_reg + rl);
                        ctl      <= '{op: CC_WRITE, pos: 9'(idx_reg)};
                    end
                    else if (pred_reg)
                    begin
                        wr_start <= pend_reg[START_W-1:0];
                        wr_len   <= COUNT_W'(AW'(plen_reg) + n_reg);
                        ctl      <= '{op: CC_WRITE, pos: 9'(idx_reg) - 9'd1};
                    end
                    else if (count_reg >= CNT_W'(MAX_REGIONS))
                        status_reg <= ST_FULL;
                    else
                    begin
                        wr_start  <= s_reg[START_W-1:0];
                        wr_len    <= n_reg[COUNT_W-1:0];
                        ctl       <= '{op: CC_SHR, pos: 9'(idx_reg)};
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_FIX;
                    end
                end
                S_FIX:
                begin
                    // Second command after a shift: write the new entries.
                    if (kind_reg == REQ_CLAIM)
                        ctl <= '{op: CC_WRITE2, pos: 9'(idx_reg)};
                    else
                        ctl <= '{op: CC_WRITE, pos: 9'(idx_reg)};
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!ovalid_reg || !out_stall)
                    begin
                        ostatus_reg <= status_reg;
                        fcount_reg  <= FCOUNT_W'(count_reg);
                        ovalid_reg  <= 1'b1;
                        busy_reg    <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Count never exceeds the table size.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("range count above table size");

    // No new request is taken while one is in flight.
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> in_stall)
        else $error("request accepted while busy");

    // A result beat appears only on leaving the done state.
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result beat without finished request");

    // Count changes by at most one per request step.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_APPLY) |=>
        (count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1
         || count_reg == $past(count_reg) - 1'b1))
        else $error("range count jumped");

endmodule
